@@ design/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg: shared definitions for the pressure sensor compensation block
// Widths, shift amounts, register map, the model select and the structs that
// travel between the configuration block and the two datapath halves.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Field widths at the ports.
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRESS_W = 32;

  // Configuration port.
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 5;

  // Internal widths, sized from the value ranges of the inputs and words.
  localparam int DELTA_W = RAW_W + 1;          // raw minus reference, signed
  localparam int PROD_W  = DELTA_W + CAL_W + 1; // delta times a 16-bit word
  localparam int DSQ_W   = 2 * RAW_W;          // delta squared, unsigned
  localparam int TEMP_SHIFT = 23;
  localparam int LO_W    = PROD_W - TEMP_SHIFT; // first-order temp minus 20 C
  localparam int SQ_W    = 35;                 // squares of the low terms
  localparam int CORR_T_W = 17;                // temperature correction
  localparam int OFF_W   = 41;                 // offset, signed
  localparam int SENS_W  = 40;                 // sensitivity, signed
  localparam int SENS_SPLIT = 20;              // sensitivity split for multiply
  localparam int PP_LO_W = SENS_SPLIT + RAW_W;
  localparam int PP_HI_W = SENS_W - SENS_SPLIT + RAW_W + 1;
  localparam int FULL_W  = 64;                 // sensitivity times pressure
  localparam int PRESS_DIV_SHIFT = 21;
  localparam int Q1_W    = FULL_W - PRESS_DIV_SHIFT;
  localparam int DIFF_W  = Q1_W + 1;
  localparam int PRESS_OUT_SHIFT = 15;

  // Shift amounts of the temperature correction terms.
  localparam int CORR_SHIFT_A = 33;  // first model, cold
  localparam int CORR_SHIFT_B = 37;  // first model, warm
  localparam int CORR_SHIFT_C = 31;  // second model, cold

  // Shift amounts of the first-order offset and sensitivity.
  localparam int OFF_SHL_FIRST   = 16;
  localparam int OFF_SHR_FIRST   = 7;
  localparam int OFF_SHL_SECOND  = 17;
  localparam int OFF_SHR_SECOND  = 6;
  localparam int SENS_SHL_FIRST  = 15;
  localparam int SENS_SHR_FIRST  = 8;
  localparam int SENS_SHL_SECOND = 16;
  localparam int SENS_SHR_SECOND = 7;

  // 20.00 C and the distance from 20.00 C down to -15.00 C.
  localparam logic signed [LO_W-1:0] TEMP_REF  = LO_W'(2000);
  localparam logic signed [LO_W-1:0] VL_OFFSET = LO_W'(3500);

  // Pipeline register stages, the output register included.
  localparam int LATENCY = 10;

  // Register map, word index into the configuration space.
  typedef enum logic [2:0] {
    REG_SENSOR_MODEL      = 3'd0,
    REG_SENS_GAIN         = 3'd1,
    REG_OFFSET_BASE       = 3'd2,
    REG_SENS_TEMP_COEFF   = 3'd3,
    REG_OFFSET_TEMP_COEFF = 3'd4,
    REG_REF_TEMPERATURE   = 3'd5,
    REG_TEMP_GAIN         = 3'd6
  } psc_reg_e;

  typedef enum logic {
    MODEL_FIRST  = 1'b0,
    MODEL_SECOND = 1'b1
  } psc_model_e;

  typedef struct packed {
    psc_model_e             sensor_model;
    logic [CAL_W-1:0]       sens_gain;
    logic [CAL_W-1:0]       offset_base;
    logic [CAL_W-1:0]       sens_temp_coeff;
    logic [CAL_W-1:0]       offset_temp_coeff;
    logic [CAL_W-1:0]       ref_temperature;
    logic [CAL_W-1:0]       temp_gain;
  } psc_cfg_t;

  // Hand-off from the temperature half to the pressure half.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [SQ_W-1:0]          losq;
    logic [SQ_W-1:0]          vlsq;
    logic                     low;   // below 20.00 C
    logic                     vlow;  // below -15.00 C
    logic signed [OFF_W-1:0]  off1;
    logic signed [SENS_W-1:0] sens1;
    logic [RAW_W-1:0]         rp;
  } psc_mid_t;

endpackage

@@ design/psc_if.sv @@
// ----------------------------------------------------------------------------
// psc_if: valid/ready channels of the pressure sensor compensation block
// One channel carries a raw reading pair in, the other a compensated result.
// ----------------------------------------------------------------------------
interface psc_in_if;
  import psc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface psc_out_if;
  import psc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [TEMP_W-1:0]  temperature_centi;
  logic signed [PRESS_W-1:0] pressure_value;

  modport source (output valid, output temperature_centi, output pressure_value,
                  input ready);
  modport sink   (input valid, input temperature_centi, input pressure_value,
                  output ready);
endinterface

@@ design/psc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// psc_cfg_regs: configuration registers on an APB-style port
// Holds the model select and the six calibration words; reads return them.
// ----------------------------------------------------------------------------
module psc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psc_pkg::PADDR_W-1:0]  paddr,
  input  logic [psc_pkg::APB_DW-1:0]   pwdata,
  output logic [psc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output psc_pkg::psc_cfg_t            cfg_o
);
  import psc_pkg::*;

  psc_cfg_t cfg_d, cfg_q;
  psc_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = psc_reg_e'(paddr[PADDR_W-1:2]);

  // Write decode; an address past the last register is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SENSOR_MODEL:      cfg_d.sensor_model      = psc_model_e'(pwdata[0]);
        REG_SENS_GAIN:         cfg_d.sens_gain         = pwdata[CAL_W-1:0];
        REG_OFFSET_BASE:       cfg_d.offset_base       = pwdata[CAL_W-1:0];
        REG_SENS_TEMP_COEFF:   cfg_d.sens_temp_coeff   = pwdata[CAL_W-1:0];
        REG_OFFSET_TEMP_COEFF: cfg_d.offset_temp_coeff = pwdata[CAL_W-1:0];
        REG_REF_TEMPERATURE:   cfg_d.ref_temperature   = pwdata[CAL_W-1:0];
        REG_TEMP_GAIN:         cfg_d.temp_gain         = pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{MODEL_FIRST, '0, '0, '0, '0, '0, '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SENSOR_MODEL:      prdata = APB_DW'(cfg_q.sensor_model);
      REG_SENS_GAIN:         prdata = APB_DW'(cfg_q.sens_gain);
      REG_OFFSET_BASE:       prdata = APB_DW'(cfg_q.offset_base);
      REG_SENS_TEMP_COEFF:   prdata = APB_DW'(cfg_q.sens_temp_coeff);
      REG_OFFSET_TEMP_COEFF: prdata = APB_DW'(cfg_q.offset_temp_coeff);
      REG_REF_TEMPERATURE:   prdata = APB_DW'(cfg_q.ref_temperature);
      REG_TEMP_GAIN:         prdata = APB_DW'(cfg_q.temp_gain);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/psc_front.sv @@
// ----------------------------------------------------------------------------
// psc_front: temperature half of the compensation pipeline (stages 1 to 4)
// Forms the temperature difference, the first-order products, the temperature
// correction and first-order offset and sensitivity, then the squared terms.
// ----------------------------------------------------------------------------
module psc_front (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  psc_pkg::psc_cfg_t          cfg_i,
  input  logic [psc_pkg::RAW_W-1:0]  raw_temperature_i,
  input  logic [psc_pkg::RAW_W-1:0]  raw_pressure_i,
  output psc_pkg::psc_mid_t          mid_o
);
  import psc_pkg::*;

  // Stage 1 registers.
  logic signed [DELTA_W-1:0] delta_d, delta_q;
  logic [RAW_W-1:0]          rp1_q;
  // Stage 2 registers.
  logic signed [PROD_W-1:0]    dt_d, dt_q, ot_d, ot_q, st_d, st_q;
  logic signed [2*DELTA_W-1:0] dsq_full;
  logic [DSQ_W-1:0]            dsq_d, dsq_q;
  logic [RAW_W-1:0]            rp2_q;
  // Stage 3 registers.
  logic signed [LO_W-1:0]   lo_d, lo_q;
  logic [CORR_T_W-1:0]      corr_d, corr_q;
  logic signed [OFF_W-1:0]  off1_d, off1_q;
  logic signed [SENS_W-1:0] sens1_d, sens1_q;
  logic [RAW_W-1:0]         rp3_q;
  logic [DSQ_W+2:0]         dsq7;
  logic [DSQ_W-CORR_SHIFT_A-1:0] sq_a;
  logic [CORR_T_W-1:0]      corr_a, corr_b, corr_c;
  logic                     low3;
  // Stage 4 registers.
  psc_mid_t                 mid_d, mid_q;
  logic signed [LO_W-1:0]   vl;
  logic signed [2*LO_W-1:0] losq_full, vlsq_full;

  // Stage 1: difference to the reference temperature.
  assign delta_d = $signed({1'b0, raw_temperature_i})
                 - $signed({1'b0, cfg_i.ref_temperature, 8'h00});

  // Stage 2: products of the difference with the calibration words.
  always_comb begin
    dt_d     = PROD_W'(delta_q) * PROD_W'($signed({1'b0, cfg_i.temp_gain}));
    ot_d     = PROD_W'(delta_q) * PROD_W'($signed({1'b0, cfg_i.offset_temp_coeff}));
    st_d     = PROD_W'(delta_q) * PROD_W'($signed({1'b0, cfg_i.sens_temp_coeff}));
    dsq_full = (2*DELTA_W)'(delta_q) * (2*DELTA_W)'(delta_q);
    dsq_d    = dsq_full[DSQ_W-1:0];
  end

  // Stage 3: first-order temperature (as distance to 20 C), temperature
  // correction and first-order offset and sensitivity.
  always_comb begin
    lo_d   = dt_q[PROD_W-1:TEMP_SHIFT];
    low3   = dt_q[PROD_W-1];
    dsq7   = {dsq_q, 3'b000} - {3'b000, dsq_q};
    sq_a   = dsq_q[DSQ_W-1:CORR_SHIFT_A];
    corr_a = CORR_T_W'(sq_a) + CORR_T_W'({sq_a, 1'b0});
    corr_b = CORR_T_W'(dsq7[DSQ_W+2:CORR_SHIFT_B]);
    corr_c = CORR_T_W'(dsq_q[DSQ_W-1:CORR_SHIFT_C]);
    unique case (cfg_i.sensor_model)
      MODEL_FIRST: begin
        corr_d  = low3 ? corr_a : corr_b;
        off1_d  = (OFF_W'($signed({1'b0, cfg_i.offset_base})) <<< OFF_SHL_FIRST)
                + OFF_W'(ot_q >>> OFF_SHR_FIRST);
        sens1_d = (SENS_W'($signed({1'b0, cfg_i.sens_gain})) <<< SENS_SHL_FIRST)
                + SENS_W'(st_q >>> SENS_SHR_FIRST);
      end
      MODEL_SECOND: begin
        corr_d  = low3 ? corr_c : '0;
        off1_d  = (OFF_W'($signed({1'b0, cfg_i.offset_base})) <<< OFF_SHL_SECOND)
                + OFF_W'(ot_q >>> OFF_SHR_SECOND);
        sens1_d = (SENS_W'($signed({1'b0, cfg_i.sens_gain})) <<< SENS_SHL_SECOND)
                + SENS_W'(st_q >>> SENS_SHR_SECOND);
      end
    endcase
  end

  // Stage 4: squares of the cold-range terms and the final temperature.
  always_comb begin
    vl             = lo_q + VL_OFFSET;
    losq_full      = (2*LO_W)'(lo_q) * (2*LO_W)'(lo_q);
    vlsq_full      = (2*LO_W)'(vl) * (2*LO_W)'(vl);
    mid_d.temp     = TEMP_W'(lo_q + TEMP_REF) - $signed({2'b00, corr_q});
    mid_d.losq     = losq_full[SQ_W-1:0];
    mid_d.vlsq     = vlsq_full[SQ_W-1:0];
    mid_d.low      = lo_q[LO_W-1];
    mid_d.vlow     = vl[LO_W-1];
    mid_d.off1     = off1_q;
    mid_d.sens1    = sens1_q;
    mid_d.rp       = rp3_q;
  end

  // Pipeline registers; the whole pipe holds when en_i is low.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta_q <= delta_d;
      rp1_q   <= raw_pressure_i;
      dt_q    <= dt_d;
      ot_q    <= ot_d;
      st_q    <= st_d;
      dsq_q   <= dsq_d;
      rp2_q   <= rp1_q;
      lo_q    <= lo_d;
      corr_q  <= corr_d;
      off1_q  <= off1_d;
      sens1_q <= sens1_d;
      rp3_q   <= rp2_q;
      mid_q   <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

@@ design/psc_back.sv @@
// ----------------------------------------------------------------------------
// psc_back: pressure half of the compensation pipeline (stages 5 to 10)
// Applies the second-order offset and sensitivity corrections, multiplies by
// the raw pressure in two partial products and scales the result.
// ----------------------------------------------------------------------------
module psc_back (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  psc_pkg::psc_model_e               model_i,
  input  psc_pkg::psc_mid_t                 mid_i,
  output logic signed [psc_pkg::TEMP_W-1:0] temperature_o,
  output logic signed [psc_pkg::PRESS_W-1:0] pressure_o
);
  import psc_pkg::*;

  // Stage 5 registers.
  logic [OFF_W-1:0]         offa_d, offa_q, offb_d, offb_q;
  logic [SENS_W-1:0]        sensa_d, sensa_q, sensb_d, sensb_q;
  logic signed [OFF_W-1:0]  off5_q;
  logic signed [SENS_W-1:0] sens5_q;
  logic signed [TEMP_W-1:0] temp5_q;
  logic [RAW_W-1:0]         rp5_q;
  logic [OFF_W-1:0]         l, v, l3, l61, v7, v15;
  logic [SENS_W-1:0]        ls, vs, l5;
  // Stage 6 registers.
  logic signed [OFF_W-1:0]  offset_d, offset6_q;
  logic signed [SENS_W-1:0] sens_d, sens6_q;
  logic signed [TEMP_W-1:0] temp6_q;
  logic [RAW_W-1:0]         rp6_q;
  // Stage 7 registers.
  logic [PP_LO_W-1:0]        pplo_d, pplo_q;
  logic signed [PP_HI_W-1:0] pphi_d, pphi_q;
  logic signed [OFF_W-1:0]   offset7_q;
  logic signed [TEMP_W-1:0]  temp7_q;
  // Stage 8 registers.
  logic signed [FULL_W-1:0]  prod_d, prod_q;
  logic signed [OFF_W-1:0]   offset8_q;
  logic signed [TEMP_W-1:0]  temp8_q;
  // Stage 9 registers.
  logic signed [FULL_W-1:0]  prod_bias;
  logic signed [Q1_W-1:0]    q1_d, q1_q;
  logic signed [OFF_W-1:0]   offset9_q;
  logic signed [TEMP_W-1:0]  temp9_q;
  // Stage 10 registers.
  logic signed [DIFF_W-1:0]  diff, diff_bias;
  logic signed [PRESS_W-1:0] press_d, press_q;
  logic signed [TEMP_W-1:0]  temp10_q;

  // Stage 5: scaled correction terms by shift and add, selected per model
  // and temperature range.
  always_comb begin
    l   = OFF_W'(mid_i.losq);
    v   = OFF_W'(mid_i.vlsq);
    ls  = SENS_W'(mid_i.losq);
    vs  = SENS_W'(mid_i.vlsq);
    l3  = l + (l << 1);
    l61 = (l << 6) - (l << 2) + l;
    v7  = (v << 3) - v;
    v15 = (v << 4) - v;
    l5  = ls + (ls << 2);
    offa_d  = '0;
    offb_d  = '0;
    sensa_d = '0;
    sensb_d = '0;
    unique case (model_i)
      MODEL_FIRST: begin
        if (mid_i.low) begin
          offa_d  = l3 >> 1;
          sensa_d = l5 >> 3;
          if (mid_i.vlow) begin
            offb_d  = v7;
            sensb_d = vs << 2;
          end
        end else begin
          offa_d = l >> 4;
        end
      end
      MODEL_SECOND: begin
        if (mid_i.low) begin
          offa_d  = l61 >> 4;
          sensa_d = ls << 1;
          if (mid_i.vlow) begin
            offb_d  = v15;
            sensb_d = vs << 3;
          end
        end
      end
    endcase
  end

  // Stage 6: corrected offset and sensitivity.
  always_comb begin
    offset_d = off5_q - $signed(offa_q) - $signed(offb_q);
    sens_d   = sens5_q - $signed(sensa_q) - $signed(sensb_q);
  end

  // Stage 7: sensitivity times raw pressure as two partial products.
  always_comb begin
    pplo_d = PP_LO_W'(sens6_q[SENS_SPLIT-1:0]) * PP_LO_W'(rp6_q);
    pphi_d = PP_HI_W'($signed(sens6_q[SENS_W-1:SENS_SPLIT]))
           * PP_HI_W'($signed({1'b0, rp6_q}));
  end

  // Stage 8: combine the partial products.
  assign prod_d = (FULL_W'(pphi_q) <<< SENS_SPLIT) + FULL_W'($signed({1'b0, pplo_q}));

  // Stage 9: divide by 2^21, rounding toward zero.
  always_comb begin
    prod_bias = prod_q + $signed({{(FULL_W-PRESS_DIV_SHIFT){1'b0}},
                                  {PRESS_DIV_SHIFT{prod_q[FULL_W-1]}}});
    q1_d      = prod_bias[FULL_W-1:PRESS_DIV_SHIFT];
  end

  // Stage 10: subtract the offset and divide by 2^15, rounding toward zero.
  // The magnitude stays below 2^29 for every input, so the 32-bit result
  // never reaches its saturation limits.
  always_comb begin
    diff      = DIFF_W'(q1_q) - DIFF_W'(offset9_q);
    diff_bias = diff + $signed({{(DIFF_W-PRESS_OUT_SHIFT){1'b0}},
                                {PRESS_OUT_SHIFT{diff[DIFF_W-1]}}});
    press_d   = PRESS_W'($signed(diff_bias[DIFF_W-1:PRESS_OUT_SHIFT]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      offa_q    <= offa_d;
      offb_q    <= offb_d;
      sensa_q   <= sensa_d;
      sensb_q   <= sensb_d;
      off5_q    <= mid_i.off1;
      sens5_q   <= mid_i.sens1;
      temp5_q   <= mid_i.temp;
      rp5_q     <= mid_i.rp;
      offset6_q <= offset_d;
      sens6_q   <= sens_d;
      temp6_q   <= temp5_q;
      rp6_q     <= rp5_q;
      pplo_q    <= pplo_d;
      pphi_q    <= pphi_d;
      offset7_q <= offset6_q;
      temp7_q   <= temp6_q;
      prod_q    <= prod_d;
      offset8_q <= offset7_q;
      temp8_q   <= temp7_q;
      q1_q      <= q1_d;
      offset9_q <= offset8_q;
      temp9_q   <= temp8_q;
      press_q   <= press_d;
      temp10_q  <= temp9_q;
    end
  end

  assign temperature_o = temp10_q;
  assign pressure_o    = press_q;

endmodule

@@ design/pressure_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_compensation: second-order barometric sensor compensation
//
// A beat on in_i carries one raw temperature and one raw pressure reading.
// A beat on out_o carries the compensated temperature in 0.01 C and the
// compensated pressure. Both channels use valid/ready. Reads of the APB-style
// port return the model select and the six calibration words; the user writes
// them only while no reading is in flight, which the block does not enforce.
//
// The datapath is a ten-stage pipeline: one beat enters per cycle while the
// output is not stalled. Each result moves through the stage registers in
// order and is loaded into the output register, from which out_o offers it.
// The length is set by the multiplier stages (difference products, squares,
// the split sensitivity times pressure product) and the rounding adders.
//
// When the receiver holds out_o.ready low with a result waiting, the whole
// pipeline freezes and in_i.ready drops; no beat is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psc_pkg::PADDR_W-1:0]  paddr,
  input  logic [psc_pkg::APB_DW-1:0]   pwdata,
  output logic [psc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  psc_in_if.sink                       in_i,
  psc_out_if.source                    out_o
);
  import psc_pkg::*;

  psc_cfg_t             cfg;
  psc_mid_t             mid;
  logic                 pipe_en;
  logic [LATENCY-1:0]   valid_q;

  // Configuration registers.
  psc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The pipe moves whenever the output register is empty or being taken.
  assign pipe_en    = !valid_q[LATENCY-1] || out_o.ready;
  assign in_i.ready = pipe_en;

  // Valid bits travel alongside the datapath stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pipe_en) begin
      valid_q <= {valid_q[LATENCY-2:0], in_i.valid};
    end
  end

  psc_front u_front (
    .clk_i             (clk_i),
    .en_i              (pipe_en),
    .cfg_i             (cfg),
    .raw_temperature_i (in_i.raw_temperature),
    .raw_pressure_i    (in_i.raw_pressure),
    .mid_o             (mid)
  );

  psc_back u_back (
    .clk_i         (clk_i),
    .en_i          (pipe_en),
    .model_i       (cfg.sensor_model),
    .mid_i         (mid),
    .temperature_o (out_o.temperature_centi),
    .pressure_o    (out_o.pressure_value)
  );

  assign out_o.valid = valid_q[LATENCY-1];

endmodule

@@ design/psc_checker.sv @@
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for the pressure sensor compensation block
// Watches both channels and flags stall, backpressure and reset slips.
// ----------------------------------------------------------------------------
module psc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [psc_pkg::TEMP_W-1:0]  temperature_i,
  input logic signed [psc_pkg::PRESS_W-1:0] pressure_i
);

  // The output is empty in the first cycle after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("output beat shown right after reset");

  // Input is taken exactly when the output register can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output backpressure");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(temperature_i) && $stable(pressure_i))
    else $error("output payload changed while stalled");

  // Unused in the checks above but kept visible for waveform debug.
  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> in_ready_i)
    else $error("input beat without ready");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .temperature_i (out_o.temperature_centi),
  .pressure_i    (out_o.pressure_value)
);
